// ----- src/fmbm_pkg.sv -----
package fmbm_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int PAT_W           = 64;
	localparam int PLEN_W          = 4;
	localparam int PAT_IDX_W       = 3;
	localparam int CFG_IDX_W       = 1;
	localparam logic [7:0] MASK_CHAR = 8'h2A;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_beat_t;

endpackage

// ----- src/fmbm_match.sv -----
// Inserts the new byte behind the held bytes, compares the newest len bytes
// with the pattern and masks them on the first hit of the current text.
module fmbm_match import fmbm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
	parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  logic [MAX_PATTERN-1:0][7:0] window,
	input  logic [LEN_W-1:0]            fill,
	input  logic [LEN_W-1:0]            fill_new,
	input  logic [7:0]                  new_byte,
	input  logic [PAT_W-1:0]            pattern,
	input  logic [LEN_W-1:0]            len,
	input  logic                        match_done,
	output logic [MAX_PATTERN-1:0][7:0] masked,
	output logic                        hit
);

	logic [MAX_PATTERN-1:0][7:0] ins;
	logic [MAX_PATTERN-1:0]      in_rng;
	logic [MAX_PATTERN-1:0]      eq;
	logic [LEN_W-1:0]            base;

	assign base = fill_new - len;

	always_comb begin
		logic [LEN_W-1:0]     pos;
		logic [PAT_IDX_W-1:0] pidx;
		ins = window;
		ins[fill[IDX_W-1:0]] = new_byte;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pos       = LEN_W'(j);
			pidx      = PAT_IDX_W'(pos - base);
			in_rng[j] = (pos >= base) && (pos < fill_new);
			eq[j]     = !in_rng[j] || (ins[j] == pattern[8*pidx +: 8]);
		end
		hit = (len != '0) && !match_done && (fill_new >= len) && (&eq);
		for (int j = 0; j < MAX_PATTERN; j++) begin
			masked[j] = (hit && in_rng[j]) ? MASK_CHAR : ins[j];
		end
	end

endmodule

// ----- src/fmbm_outq.sv -----
// Two-entry output queue; the head drives the output port, so the block can
// take another beat while the head is stalled.
module fmbm_outq import fmbm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_beat_t push_data,
	input  logic      pop,
	output logic      head_valid,
	output out_beat_t head_data,
	output logic      full
);

	out_beat_t  slot0_q;
	out_beat_t  slot1_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = slot0_q;
	assign full       = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd2) begin
				slot0_q <= slot1_q;
				slot1_q <= push_data;
			end else begin
				slot0_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ----- src/first_match_byte_masker.sv -----
// A byte that leaves on its own input beat is registered into the output queue on accept.
// Throughput: one input beat per cycle while the output queue is not full and each beat
// releases at most one byte. A beat that releases k bytes (the final beat, or one after a
// length change) stalls input; the window sends one byte per cycle into a non-full queue.
// Reset clears the window fill, the match flag, the output queue and both
// configuration registers; the window bytes themselves are not cleared.
module first_match_byte_masker import fmbm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [PAT_W-1:0]            pattern_q;
	logic [PLEN_W-1:0]           plen_q;
	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [LEN_W-1:0]            fill_q;
	logic [LEN_W-1:0]            pend_q;
	logic                        last_pend_q;
	logic                        match_q;

	logic [LEN_W-1:0]            len;
	logic [LEN_W-1:0]            keep;
	logic [LEN_W-1:0]            fill_new;
	logic [LEN_W-1:0]            emit;
	logic [MAX_PATTERN-1:0][7:0] masked;
	logic [MAX_PATTERN-1:0][7:0] masked_sh;
	logic [MAX_PATTERN-1:0][7:0] window_sh;
	logic                        hit;
	logic                        accept;
	logic                        drain;
	logic                        q_full;
	logic                        q_push;
	logic                        q_pop;
	out_beat_t                   q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: plen_q    <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len      = (plen_q > PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
	                                                  : LEN_W'(plen_q);
	assign keep     = (len == '0) ? '0 : len - LEN_W'(1);
	assign fill_new = fill_q + LEN_W'(1);
	assign emit     = in_data.in_last ? fill_new
	                : ((fill_new > keep) ? fill_new - keep : '0);

	assign in_stall = (pend_q != '0) || q_full;
	assign accept   = in_valid && !in_stall;
	assign drain    = (pend_q != '0) && !q_full;

	fmbm_match #(
		.MAX_PATTERN(MAX_PATTERN),
		.LEN_W      (LEN_W),
		.IDX_W      (IDX_W)
	) u_match (
		.window    (window_q),
		.fill      (fill_q),
		.fill_new  (fill_new),
		.new_byte  (in_data.in_byte),
		.pattern   (pattern_q),
		.len       (len),
		.match_done(match_q),
		.masked    (masked),
		.hit       (hit)
	);

	// Removing the oldest byte moves every held byte down one place.
	always_comb begin
		window_sh = window_q;
		masked_sh = masked;
		for (int j = 0; j < MAX_PATTERN - 1; j++) begin
			window_sh[j] = window_q[j+1];
			masked_sh[j] = masked[j+1];
		end
	end

	always_comb begin
		q_push = 1'b0;
		q_data = '{out_byte: masked[0],
		           out_last: in_data.in_last && (emit == LEN_W'(1))};
		if (drain) begin
			q_push = 1'b1;
			q_data = '{out_byte: window_q[0],
			           out_last: last_pend_q && (pend_q == LEN_W'(1))};
		end else if (accept && (emit != '0)) begin
			q_push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_q      <= '0;
			last_pend_q <= 1'b0;
			match_q     <= 1'b0;
		end else if (drain) begin
			fill_q <= fill_q - LEN_W'(1);
			pend_q <= pend_q - LEN_W'(1);
		end else if (accept) begin
			match_q     <= in_data.in_last ? 1'b0 : (match_q || hit);
			last_pend_q <= in_data.in_last;
			if (emit != '0) begin
				fill_q <= fill_new - LEN_W'(1);
				pend_q <= emit - LEN_W'(1);
			end else begin
				fill_q <= fill_new;
				pend_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			window_q <= window_sh;
		end else if (accept) begin
			window_q <= (emit != '0) ? masked_sh : masked;
		end
	end

	assign q_pop = out_valid && !out_stall;

	fmbm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head_valid(out_valid),
		.head_data (out_data),
		.full      (q_full)
	);

endmodule

// ----- dv/first_match_byte_masker_test.sv -----
module first_match_byte_masker_test;
	import fmbm_pkg::*;

	localparam int IDLE_PCT      = 34;
	localparam int RANDOM_BEATS  = 360;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DIR_ROWS      = 32;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [PAT_W-1:0]     reg_value;
		in_beat_t             beat;
		logic                 typed;
		out_beat_t            want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_beat_t            out_data;

	// Shadow of the window, the match flag and both registers.
	logic [7:0]        win_bytes [MAX_PATTERN_DEF];
	int                win_fill = 0;
	logic              hit_seen = 1'b0;
	logic [PAT_W-1:0]  pat_reg = '0;
	logic [PLEN_W-1:0] plen_reg = '0;

	out_beat_t released_q [$];
	out_beat_t masked_out_q [$];

	int   errors = 0;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	first_match_byte_masker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [PAT_W-1:0] value);
		dir_row_t r;
		r = '0;
		r.is_cfg    = 1'b1;
		r.reg_index = idx;
		r.reg_value = value;
		return r;
	endfunction

	function automatic dir_row_t beat_row(input logic [7:0] ch, input logic last);
		dir_row_t r;
		r = '0;
		r.beat.in_byte = ch;
		r.beat.in_last = last;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic [7:0] ch, input logic last,
			input logic [7:0] want_ch, input logic want_last);
		dir_row_t r;
		r = beat_row(ch, last);
		r.typed         = 1'b1;
		r.want.out_byte = want_ch;
		r.want.out_last = want_last;
		return r;
	endfunction

	function automatic logic [7:0] random_text_char();
		if ($urandom_range(99) < 70)
			return 8'(8'h61 + $urandom_range(2));
		return 8'($urandom_range(1, 255));
	endfunction

	// Appends the byte, masks the newest window on the first match of the text,
	// and releases whatever no longer fits in the window (all of it on the last beat).
	task automatic shift_and_mask(input in_beat_t b);
		int        len;
		int        keep;
		int        base;
		logic      eq;
		out_beat_t ob;
		len  = (plen_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(plen_reg);
		keep = (len == 0) ? 0 : len - 1;
		released_q.delete();
		if (win_fill >= MAX_PATTERN_DEF)
			win_fill = MAX_PATTERN_DEF - 1;
		win_bytes[win_fill] = b.in_byte;
		win_fill++;
		if (len > 0 && !hit_seen && win_fill >= len) begin
			base = win_fill - len;
			eq   = 1'b1;
			for (int i = 0; i < len; i++)
				if (win_bytes[base + i] != pat_reg[8*i +: 8])
					eq = 1'b0;
			if (eq) begin
				for (int i = 0; i < len; i++)
					win_bytes[base + i] = MASK_CHAR;
				hit_seen = 1'b1;
			end
		end
		while (win_fill > (b.in_last ? 0 : keep)) begin
			ob.out_byte = win_bytes[0];
			for (int i = 1; i < win_fill; i++)
				win_bytes[i - 1] = win_bytes[i];
			win_fill--;
			ob.out_last = b.in_last && (win_fill == 0);
			released_q.push_back(ob);
		end
		if (b.in_last)
			hit_seen = 1'b0;
	endtask

	task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		shift_and_mask(b);
		if (typed)
			masked_out_q.push_back(want);
		else
			foreach (released_q[j])
				masked_out_q.push_back(released_q[j]);
	endtask

	// Registers change only once every released byte has been seen.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
		in_valid <= 1'b0;
		while (masked_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PATTERN_BYTES)
			pat_reg = value;
		else
			plen_reg = value[PLEN_W-1:0];
	endtask

	task automatic flag_error(input string what, input out_beat_t want, input out_beat_t got);
		errors++;
		if (errors <= 10)
			$display("%s: expected byte %h last %b, got byte %h last %b",
				what, want.out_byte, want.out_last, got.out_byte, got.out_last);
	endtask

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (masked_out_q.size() == 0) begin
				flag_error("unexpected byte", '0, out_data);
			end else begin
				want = masked_out_q.pop_front();
				if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last)
					flag_error("wrong byte", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		dir_row_t         dir_table [DIR_ROWS];
		logic [7:0]       text_q [$];
		logic [PAT_W-1:0] pat_pick;
		logic [7:0]       ch;
		in_beat_t         b;
		int               n_sent;
		int               calm_from;
		int               text_len;
		int               eff_len;
		int               pick;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_table = '{
			// Pass-through after reset.
			known_row(8'h01, 1'b0, 8'h01, 1'b0),
			known_row(8'h80, 1'b0, 8'h80, 1'b0),
			known_row(8'hFF, 1'b1, 8'hFF, 1'b1),
			// Only the first occurrence of "abc" is masked.
			cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261),
			cfg_row(REG_PATTERN_LENGTH, 64'd3),
			beat_row(8'h78, 1'b0),
			beat_row(8'h61, 1'b0),
			beat_row(8'h62, 1'b0),
			beat_row(8'h63, 1'b0),
			beat_row(8'h61, 1'b0),
			beat_row(8'h62, 1'b0),
			beat_row(8'h63, 1'b1),
			// An oversized length acts as the full window.
			cfg_row(REG_PATTERN_BYTES, '1),
			cfg_row(REG_PATTERN_LENGTH, 64'd15),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b1),
			// Shrink and then grow the length in the middle of a text; the grown
			// pattern has zero bytes in it.
			cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_7A79_7877),
			cfg_row(REG_PATTERN_LENGTH, 64'd4),
			beat_row(8'h71, 1'b0),
			beat_row(8'h77, 1'b0),
			beat_row(8'h78, 1'b0),
			cfg_row(REG_PATTERN_LENGTH, 64'd1),
			beat_row(8'h77, 1'b0),
			cfg_row(REG_PATTERN_LENGTH, 64'd8),
			beat_row(8'h78, 1'b0),
			beat_row(8'h79, 1'b1)
		};

		foreach (dir_table[k]) begin
			if (dir_table[k].is_cfg)
				write_reg(dir_table[k].reg_index, dir_table[k].reg_value);
			else
				send_beat(dir_table[k].beat, dir_table[k].typed, dir_table[k].want);
		end

		n_sent    = 0;
		calm_from = $urandom_range(100, 200);
		while (n_sent < RANDOM_BEATS) begin
			if ($urandom_range(99) < 50) begin
				for (int i = 0; i < 8; i++)
					pat_pick[8*i +: 8] = ($urandom_range(99) < 75) ?
						8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(255));
				write_reg(REG_PATTERN_BYTES, pat_pick);
				pick = $urandom_range(99);
				write_reg(REG_PATTERN_LENGTH, PAT_W'((pick < 6) ? 0 :
					(pick < 14) ? $urandom_range(9, 15) : $urandom_range(1, 8)));
			end

			// Texts are mostly short and seeded with copies of the pattern so that
			// matches, near misses and repeated occurrences all come up.
			eff_len  = (plen_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(plen_reg);
			text_len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
			text_q.delete();
			while (text_q.size() < text_len) begin
				if (eff_len != 0 && $urandom_range(99) < 30) begin
					for (int i = 0; i < eff_len; i++) begin
						ch = pat_reg[8*i +: 8];
						if ($urandom_range(99) < 15)
							ch = random_text_char();
						text_q.push_back((ch == 8'h00) ? 8'h01 : ch);
					end
				end else begin
					text_q.push_back(random_text_char());
				end
			end

			foreach (text_q[i]) begin
				if (i != 0 && $urandom_range(99) < 3)
					write_reg(REG_PATTERN_LENGTH, PAT_W'($urandom_range(15)));
				b.in_byte = text_q[i];
				b.in_last = (i == text_q.size() - 1);
				send_beat(b, 1'b0, '0);
				n_sent++;
				calm = (n_sent >= calm_from) && (n_sent < calm_from + 70);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (masked_out_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
